// File: src/u8u16_pkg.sv
// Shared types and constants for the strict UTF-8 to UTF-16 decoder.
package u8u16_pkg;

    // Result kinds
    localparam logic [1:0] KIND_UNIT   = 2'd0;
    localparam logic [1:0] KIND_ACCEPT = 2'd1;
    localparam logic [1:0] KIND_REJECT = 2'd2;

    // Most results that one input word can cause
    localparam int MAX_RESULTS = 3;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

    // Lead byte classification
    localparam logic [7:0] LEAD2_MASK = 8'hE0;
    localparam logic [7:0] LEAD2_VAL  = 8'hC0;
    localparam logic [7:0] LEAD3_MASK = 8'hF0;
    localparam logic [7:0] LEAD3_VAL  = 8'hE0;
    localparam logic [7:0] LEAD4_MASK = 8'hF8;
    localparam logic [7:0] LEAD4_VAL  = 8'hF0;
    localparam logic [7:0] CONT_MASK  = 8'hC0;
    localparam logic [7:0] CONT_VAL   = 8'h80;
    localparam logic [7:0] CONT_BITS  = 8'h3F;

    // Code point limits
    localparam logic [20:0] CP_MIN2     = 21'h00080;
    localparam logic [20:0] CP_MIN3     = 21'h00800;
    localparam logic [20:0] CP_MIN4     = 21'h10000;
    localparam logic [20:0] CP_SURR_LO  = 21'h0D800;
    localparam logic [20:0] CP_SURR_HI  = 21'h0DFFF;
    localparam logic [20:0] CP_MAX      = 21'h10FFFF;
    localparam logic [15:0] HI_SURR_BASE = 16'hD800;
    localparam logic [15:0] LO_SURR_BASE = 16'hDC00;
    localparam logic [15:0] HI_SURR_END  = 16'hDBFF;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_string;
    } char_word_t;

    typedef struct packed {
        logic [15:0] code_unit;
        logic [1:0]  kind;
        logic        last_of_run;
    } unit_word_t;

endpackage

// File: src/strict_utf8_to_utf16_decoder_core.sv
// Strict UTF-8 to UTF-16 decoder: one byte in, up to three results out.
//
// Accepts one UTF-8 byte per word on the char channel and returns UTF-16 code
// units, followed on the final byte of each string by an accepted or rejected
// status word, on the unit channel. A byte is decoded in the cycle it is
// accepted: the sequence state updates and all results it causes (none, one
// unit, a surrogate pair, plus an optional status) are loaded into a
// three-entry result buffer, which drains one word per cycle unless stalled. A
// new byte is taken when the buffer is empty or giving up its last word, so
// bytes that make zero or one result stream at one per cycle unless stalled;
// more results hold the next byte until the last one leaves. After an error
// the rest of the string is dropped and only the rejected status is returned.
// Units already sent for a rejected string must be discarded downstream.
module strict_utf8_to_utf16_decoder_core
    import u8u16_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       char_valid,
    output logic       char_stall,
    input  char_word_t char_data,
    output logic       unit_valid,
    input  logic       unit_stall,
    output unit_word_t unit_data
);

    // Decoder state
    logic [1:0]  pend_reg, pend_next;      // continuation bytes still due
    logic [1:0]  seqlen_reg, seqlen_next;  // continuation bytes in sequence
    logic [20:0] acc_reg, acc_next;        // code point so far
    logic        fail_reg, fail_next;      // current string already bad

    // Result buffer, entry 0 is the head
    unit_word_t       res_reg [MAX_RESULTS];
    unit_word_t       res_next [MAX_RESULTS];
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    logic char_take;
    logic unit_take;

    assign unit_valid = (cnt_reg != '0);
    assign unit_data  = res_reg[0];
    assign unit_take  = unit_valid && !unit_stall;
    // Room when empty or the last word leaves this cycle
    assign char_stall = !((cnt_reg == '0) ||
                          ((cnt_reg == CNT_W'(1)) && !unit_stall));
    assign char_take  = char_valid && !char_stall;

    // Decode of the presented byte
    logic [7:0]  b;
    logic        eos;
    logic        fail_now;
    logic        emit;
    logic        bad;
    logic [20:0] cp;
    logic [20:0] acc_sh;
    logic [19:0] cp_off;
    logic [15:0] unit0, unit1;
    logic [1:0]  nunits;
    logic [1:0]  stat_kind;
    logic [CNT_W-1:0] nres;
    unit_word_t  dec [MAX_RESULTS];

    always_comb
    begin
        b           = char_data.in_byte;
        eos         = char_data.end_of_string;
        pend_next   = pend_reg;
        seqlen_next = seqlen_reg;
        acc_next    = acc_reg;
        fail_next   = fail_reg;
        fail_now    = 1'b0;
        emit        = 1'b0;
        bad         = 1'b0;
        cp          = '0;
        acc_sh      = {acc_reg[14:0], b[5:0]};

        if (!fail_reg)
        begin
            if (pend_reg == 2'd0)
            begin
                priority if (!b[7])
                begin
                    emit = 1'b1;
                    cp   = {13'd0, b};
                end
                else if ((b & LEAD2_MASK) == LEAD2_VAL)
                begin
                    acc_next    = {16'd0, b[4:0]};
                    pend_next   = 2'd1;
                    seqlen_next = 2'd1;
                end
                else if ((b & LEAD3_MASK) == LEAD3_VAL)
                begin
                    acc_next    = {17'd0, b[3:0]};
                    pend_next   = 2'd2;
                    seqlen_next = 2'd2;
                end
                else if ((b & LEAD4_MASK) == LEAD4_VAL)
                begin
                    acc_next    = {18'd0, b[2:0]};
                    pend_next   = 2'd3;
                    seqlen_next = 2'd3;
                end
                else
                begin
                    fail_now = 1'b1;
                end
            end
            else if ((b & CONT_MASK) != CONT_VAL)
            begin
                fail_now = 1'b1;
            end
            else if (pend_reg == 2'd1)
            begin
                // Last continuation: range checks happen here
                unique case (seqlen_reg)
                    2'd1:    bad = acc_sh < CP_MIN2;
                    2'd2:    bad = (acc_sh < CP_MIN3) ||
                                   ((acc_sh >= CP_SURR_LO) && (acc_sh <= CP_SURR_HI));
                    default: bad = (acc_sh < CP_MIN4) || (acc_sh > CP_MAX);
                endcase
                if (bad)
                begin
                    fail_now = 1'b1;
                end
                else
                begin
                    emit        = 1'b1;
                    cp          = acc_sh;
                    pend_next   = 2'd0;
                    seqlen_next = 2'd0;
                    acc_next    = '0;
                end
            end
            else
            begin
                acc_next  = acc_sh;
                pend_next = pend_reg - 2'd1;
            end
        end

        if (fail_now)
        begin
            fail_next   = 1'b1;
            pend_next   = 2'd0;
            seqlen_next = 2'd0;
            acc_next    = '0;
        end

        // Code point to one unit or a surrogate pair
        cp_off = cp[19:0] - CP_MIN4[19:0];
        unit0  = cp[15:0];
        unit1  = '0;
        nunits = 2'd0;
        if (emit)
        begin
            if (cp < CP_MIN4)
            begin
                nunits = 2'd1;
            end
            else
            begin
                unit0  = HI_SURR_BASE + {6'd0, cp_off[19:10]};
                unit1  = LO_SURR_BASE + {6'd0, cp_off[9:0]};
                nunits = 2'd2;
            end
        end

        // Truncated sequence counts as a rejection
        stat_kind = (fail_next || (pend_next != 2'd0)) ? KIND_REJECT : KIND_ACCEPT;
        nres      = CNT_W'(nunits) + CNT_W'(eos);

        if (eos)
        begin
            pend_next   = 2'd0;
            seqlen_next = 2'd0;
            acc_next    = '0;
            fail_next   = 1'b0;
        end

        for (int i = 0; i < MAX_RESULTS; i++)
        begin
            dec[i].code_unit   = '0;
            dec[i].kind        = KIND_UNIT;
            dec[i].last_of_run = (CNT_W'(i + 1) == nres);
            if (CNT_W'(i) < CNT_W'(nunits))
            begin
                dec[i].code_unit = (i == 0) ? unit0 : unit1;
            end
            else if (CNT_W'(i) == CNT_W'(nunits))
            begin
                dec[i].kind = stat_kind;
            end
        end
    end

    // Result buffer next value
    always_comb
    begin
        cnt_next = cnt_reg;
        for (int i = 0; i < MAX_RESULTS; i++)
        begin
            res_next[i] = res_reg[i];
        end
        if (char_take)
        begin
            cnt_next = nres;
            for (int i = 0; i < MAX_RESULTS; i++)
            begin
                res_next[i] = dec[i];
            end
        end
        else if (unit_take)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
            for (int i = 0; i < MAX_RESULTS - 1; i++)
            begin
                res_next[i] = res_reg[i + 1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg   <= 2'd0;
            seqlen_reg <= 2'd0;
            acc_reg    <= '0;
            fail_reg   <= 1'b0;
            cnt_reg    <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (char_take)
            begin
                pend_reg   <= pend_next;
                seqlen_reg <= seqlen_next;
                acc_reg    <= acc_next;
                fail_reg   <= fail_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MAX_RESULTS; i++)
        begin
            res_reg[i] <= res_next[i];
        end
    end

    // Input must hold while two or more results are queued
    a_hold_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg > CNT_W'(1)) |-> char_stall)
        else $error("input taken with results still queued");

    // The last queued word always closes its run
    a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == CNT_W'(1)) |-> res_reg[0].last_of_run)
        else $error("final queued word lacks last_of_run");

    // A high surrogate is always followed by its low half
    a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
        (unit_valid && (unit_data.kind == KIND_UNIT) &&
         (unit_data.code_unit >= HI_SURR_BASE) &&
         (unit_data.code_unit <= HI_SURR_END)) |-> !unit_data.last_of_run)
        else $error("high surrogate ends a run");

    // A failed string carries no open sequence
    a_fail_clear: assert property (@(posedge clk) disable iff (!rst_n)
        fail_reg |-> ((pend_reg == 2'd0) && (seqlen_reg == 2'd0)))
        else $error("sequence state left open after error");

endmodule
